@@ design/dswc_pkg.sv @@
package dswc_pkg;

	// Default sizing
	localparam int unsigned DEF_MAX_WORD_BITS = 32;
	localparam int unsigned DEF_MAX_POSITIONS = 1024;

	// Register and field widths
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned LEN_W     = 6;
	localparam int unsigned THR_W     = 6;
	localparam int unsigned POS_CFG_W = 11;
	localparam int unsigned LOC_W     = 10;
	localparam int unsigned PEAK_W    = 6;
	localparam int unsigned CFG_IDX_W = 3;

	// Popcount grouping: mismatch bits are counted in groups of eight
	localparam int unsigned GROUP_BITS = 8;
	localparam int unsigned GROUP_CW   = 4;

	// Register reset values
	localparam logic [LEN_W-1:0]     RST_WORD_LENGTH = 6'd32;
	localparam logic [THR_W-1:0]     RST_THRESHOLD   = 6'd24;
	localparam logic [POS_CFG_W-1:0] RST_POSITIONS   = 11'd1024;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRIMARY_WORD     = 3'd0,
		REG_SECONDARY_WORD   = 3'd1,
		REG_SECONDARY_ENABLE = 3'd2,
		REG_WORD_LENGTH      = 3'd3,
		REG_DETECT_THRESHOLD = 3'd4,
		REG_SEARCH_POSITIONS = 3'd5
	} dswc_reg_t;

	// Per-item control carried down the pipeline
	typedef struct packed {
		logic clr;    // block start: peak restarts from zero
		logic score;  // a complete window is present
		logic last;   // last window of the block, result due
	} dswc_ctl_t;

endpackage

@@ design/dswc_cell.sv @@
// One window bit: shifts toward the oldest end and compares against both words
module dswc_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,        // a bit is shifted into the window
	input  logic clr,       // window starts empty before this shift
	input  logic top,       // this cell is the newest position of the window
	input  logic keep,      // this cell lies inside the word length
	input  logic bit_in,    // received bit
	input  logic up_bit,    // neighbor one position newer
	input  logic pw_bit,
	input  logic sw_bit,
	output logic win_bit,
	output logic mis_p,
	output logic mis_s
);

	logic win_q;
	logic nxt;

	// Shift in, OR with the new bit at the top, mask beyond the length
	assign nxt = keep & ((top & bit_in) | (~clr & up_bit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 1'b0;
		end else if (en) begin
			win_q <= nxt;
		end
	end

	assign win_bit = win_q;
	assign mis_p   = keep & (win_q ^ pw_bit);
	assign mis_s   = keep & (win_q ^ sw_bit);

endmodule

@@ design/dswc_score.sv @@
// Two-stage mismatch count and score for both words
module dswc_score #(
	parameter int unsigned WB = dswc_pkg::DEF_MAX_WORD_BITS,
	parameter int unsigned PW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          s1_valid,
	input  dswc_pkg::dswc_ctl_t           s1_ctl,
	input  logic [PW-1:0]                 s1_pos,
	input  logic [WB-1:0]                 mis_p,
	input  logic [WB-1:0]                 mis_s,
	input  logic [$clog2(WB+1)-1:0]       len,
	input  logic                          sec_en,
	output logic                          s3_valid,
	output dswc_pkg::dswc_ctl_t           s3_ctl,
	output logic [PW-1:0]                 s3_pos,
	output logic signed [$clog2(WB+1)+1:0] s3_sc_p,
	output logic signed [$clog2(WB+1)+1:0] s3_sc_s
);

	localparam int unsigned BW  = $clog2(WB+1);
	localparam int unsigned SW  = BW + 2;
	localparam int unsigned GB  = dswc_pkg::GROUP_BITS;
	localparam int unsigned GCW = dswc_pkg::GROUP_CW;
	localparam int unsigned NG  = (WB + GB - 1) / GB;
	localparam int unsigned PAD = NG * GB;

	logic [PAD-1:0]  mp_pad, ms_pad;
	logic [GCW-1:0]  grp_p [NG];
	logic [GCW-1:0]  grp_s [NG];
	logic [GCW-1:0]  grp_p_s2 [NG];
	logic [GCW-1:0]  grp_s_s2 [NG];
	logic            s2_valid;
	dswc_pkg::dswc_ctl_t s2_ctl;
	logic [PW-1:0]   s2_pos;
	logic [BW-1:0]   m_p, m_s;
	logic signed [SW-1:0] sc_p, sc_s;

	assign mp_pad = PAD'(mis_p);
	assign ms_pad = PAD'(mis_s);

	// Group popcounts
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_p[g] = '0;
			grp_s[g] = '0;
			for (int b = 0; b < GB; b++) begin
				grp_p[g] = grp_p[g] + GCW'(mp_pad[g*GB + b]);
				grp_s[g] = grp_s[g] + GCW'(ms_pad[g*GB + b]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			s3_valid <= 1'b0;
		end else if (adv) begin
			s2_valid <= s1_valid;
			s3_valid <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grp_p_s2 <= grp_p;
			grp_s_s2 <= grp_s;
			s2_ctl   <= s1_ctl;
			s2_pos   <= s1_pos;
			s3_ctl   <= s2_ctl;
			s3_pos   <= s2_pos;
			s3_sc_p  <= sc_p;
			s3_sc_s  <= sc_s;
		end
	end

	// Totals and score: length minus twice the mismatches
	always_comb begin
		m_p = '0;
		m_s = '0;
		for (int g = 0; g < NG; g++) begin
			m_p = m_p + BW'(grp_p_s2[g]);
			m_s = m_s + BW'(grp_s_s2[g]);
		end
		sc_p = $signed({2'b00, len}) - $signed({1'b0, m_p, 1'b0});
		sc_s = sec_en ? ($signed({2'b00, len}) - $signed({1'b0, m_s, 1'b0})) : '0;
	end

endmodule

@@ design/dswc_peak.sv @@
// Running peak per block and the result register with its stall control
module dswc_peak #(
	parameter int unsigned WB = dswc_pkg::DEF_MAX_WORD_BITS,
	parameter int unsigned PW = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s3_valid,
	input  dswc_pkg::dswc_ctl_t            s3_ctl,
	input  logic [PW-1:0]                  s3_pos,
	input  logic signed [$clog2(WB+1)+1:0] s3_sc_p,
	input  logic signed [$clog2(WB+1)+1:0] s3_sc_s,
	input  logic [dswc_pkg::THR_W-1:0]     thr,
	output logic                           adv,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           out_found,
	output logic [dswc_pkg::LOC_W-1:0]     out_loc,
	output logic                           out_type,
	output logic [dswc_pkg::PEAK_W-1:0]    out_peak
);

	localparam int unsigned BW = $clog2(WB+1);

	logic [BW-1:0] best_q;
	logic [PW-1:0] loc_q;
	logic          type_q;
	logic          out_valid_q;
	logic [BW-1:0] b0, b1, b2;
	logic [PW-1:0] l0, l1, l2;
	logic          t0, t1, t2;
	logic          upd, emit;

	// Hold the pipeline only when a second result would meet a full output
	assign adv  = !(out_valid_q && !out_ready && s3_valid && s3_ctl.last);
	assign upd  = s3_valid && adv;
	assign emit = upd && s3_ctl.last;

	// Secondary word first, then primary; strict compare keeps earlier peak
	always_comb begin
		b0 = s3_ctl.clr ? '0 : best_q;
		l0 = s3_ctl.clr ? '0 : loc_q;
		t0 = s3_ctl.clr ? 1'b0 : type_q;
		b1 = b0; l1 = l0; t1 = t0;
		if (s3_ctl.score && (s3_sc_s > $signed({2'b00, b0}))) begin
			b1 = s3_sc_s[BW-1:0];
			l1 = s3_pos;
			t1 = 1'b1;
		end
		b2 = b1; l2 = l1; t2 = t1;
		if (s3_ctl.score && (s3_sc_p > $signed({2'b00, b1}))) begin
			b2 = s3_sc_p[BW-1:0];
			l2 = s3_pos;
			t2 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			loc_q       <= '0;
			type_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd) begin
				best_q <= b2;
				loc_q  <= l2;
				type_q <= t2;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_found <= (dswc_pkg::THR_W'(b2) >= thr);
			out_loc   <= dswc_pkg::LOC_W'(l2);
			out_type  <= t2;
			out_peak  <= dswc_pkg::PEAK_W'(b2);
		end
	end

	assign out_valid = out_valid_q;

	// A stall always means a result is waiting and another is ready behind it
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> (out_valid_q && s3_valid && s3_ctl.last))
		else $error("stall without a pending result");

	// The peak never exceeds the widest word
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= BW'(WB))
		else $error("peak score out of range");

	// A result that leaves the last stage is presented next cycle
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result lost at output register");

endmodule

@@ design/dual_sync_word_correlator_top.sv @@
// Dual sync word correlator. Takes one received hard bit per transfer (tdata bit 0, with
// tuser bit 0 marking the first bit of a search block), keeps a window of the last
// word_length bits in a row of shift cells, and scores every window start against the
// primary and, if enabled, the secondary word as length minus twice the mismatches.
// After the last of search_positions windows one result transfer carries found,
// location, peak score and word type (in tuser). The block takes one bit every clock
// cycle while not held back; the result is registered through the window cell stage,
// the two popcount stages and the peak stage after the last bit's transfer. Input is
// held back only while one result waits at the output and the next result is due.
// The user must write registers via cfg_wr_en/cfg_index/cfg_data only while no block
// result is outstanding (unenforced); writing at a block boundary is the intended use.
module dual_sync_word_correlator_top #(
	parameter int unsigned MAX_WORD_BITS = dswc_pkg::DEF_MAX_WORD_BITS,
	parameter int unsigned MAX_POSITIONS = dswc_pkg::DEF_MAX_POSITIONS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // [0] rx_bit
	input  logic [0:0]                        s_axis_tuser,   // [0] block_start
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,   // [0] found, [10:1] location,
	                                                          // [16:11] peak_score
	output logic [0:0]                        m_axis_tuser,   // [0] word_type
	input  logic                              cfg_wr_en,
	input  logic [dswc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dswc_pkg::WORD_W-1:0]       cfg_data
);

	localparam int unsigned WB = (MAX_WORD_BITS < dswc_pkg::WORD_W) ?
		MAX_WORD_BITS : dswc_pkg::WORD_W;
	localparam int unsigned LW = $clog2(WB+1);
	localparam int unsigned PW = $clog2(MAX_POSITIONS);
	localparam int unsigned CW = $clog2(MAX_POSITIONS + WB);
	localparam int unsigned XW = (CW > dswc_pkg::POS_CFG_W) ? CW : dswc_pkg::POS_CFG_W;

	// Configuration registers
	logic [dswc_pkg::WORD_W-1:0]    prim_q, sec_q;
	logic                           sen_q;
	logic [dswc_pkg::LEN_W-1:0]     wl_q;
	logic [dswc_pkg::THR_W-1:0]     thr_q;
	logic [dswc_pkg::POS_CFG_W-1:0] sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_q <= '0;
			sec_q  <= '0;
			sen_q  <= 1'b0;
			wl_q   <= dswc_pkg::RST_WORD_LENGTH;
			thr_q  <= dswc_pkg::RST_THRESHOLD;
			sp_q   <= dswc_pkg::RST_POSITIONS;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dswc_pkg::REG_PRIMARY_WORD:     prim_q <= cfg_data;
				dswc_pkg::REG_SECONDARY_WORD:   sec_q  <= cfg_data;
				dswc_pkg::REG_SECONDARY_ENABLE: sen_q  <= cfg_data[0];
				dswc_pkg::REG_WORD_LENGTH:      wl_q   <= cfg_data[dswc_pkg::LEN_W-1:0];
				dswc_pkg::REG_DETECT_THRESHOLD: thr_q  <= cfg_data[dswc_pkg::THR_W-1:0];
				dswc_pkg::REG_SEARCH_POSITIONS: sp_q   <= cfg_data[dswc_pkg::POS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective length and position count, clamped to their limits
	logic [LW-1:0] len, len_m1;
	logic [XW-1:0] sp_x, pos_x;
	logic [CW-1:0] pos_eff, total;

	always_comb begin
		if (wl_q == '0) begin
			len = LW'(1);
		end else if (wl_q > dswc_pkg::LEN_W'(WB)) begin
			len = LW'(WB);
		end else begin
			len = LW'(wl_q);
		end
		sp_x = XW'(sp_q);
		if (sp_x == '0) begin
			pos_x = XW'(1);
		end else if (sp_x > XW'(MAX_POSITIONS)) begin
			pos_x = XW'(MAX_POSITIONS);
		end else begin
			pos_x = sp_x;
		end
		pos_eff = CW'(pos_x);
		total   = pos_eff + CW'(len) - CW'(1);
		len_m1  = len - LW'(1);
	end

	// Bit counter and per-transfer control
	logic          adv, accept, blk_start, ignore, win_en;
	logic [CW-1:0] seen_q, seen0, seen_new;
	logic          s1_valid;
	dswc_pkg::dswc_ctl_t s1_ctl, ctl_new;
	logic [PW-1:0] s1_pos;

	assign s_axis_tready = adv;
	assign accept    = s_axis_tvalid && adv;
	assign blk_start = s_axis_tuser[0];
	assign seen0     = blk_start ? '0 : seen_q;
	assign ignore    = (seen0 >= total);
	assign seen_new  = seen0 + CW'(1);
	assign win_en    = accept && !ignore;

	always_comb begin
		ctl_new.clr   = blk_start;
		ctl_new.score = !ignore && (seen_new >= CW'(len));
		ctl_new.last  = !ignore && (seen_new == total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (accept) begin
				seen_q <= ignore ? seen0 : seen_new;
			end
			if (adv) begin
				s1_valid <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_ctl <= ctl_new;
			s1_pos <= PW'(seen_new - CW'(len));
		end
	end

	// Row of window cells
	logic [WB-1:0] win, mis_p, mis_s;

	for (genvar j = 0; j < WB; j++) begin : g_cell
		localparam logic [LW-1:0] JV = LW'(j);
		logic up;
		if (j + 1 < WB) begin : g_up
			assign up = win[j+1];
		end else begin : g_end
			assign up = 1'b0;
		end
		dswc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (win_en),
			.clr     (blk_start),
			.top     (len_m1 == JV),
			.keep    (JV < len),
			.bit_in  (s_axis_tdata[0]),
			.up_bit  (up),
			.pw_bit  (prim_q[j]),
			.sw_bit  (sec_q[j]),
			.win_bit (win[j]),
			.mis_p   (mis_p[j]),
			.mis_s   (mis_s[j])
		);
	end

	// Scoring stages
	logic                 s3_valid;
	dswc_pkg::dswc_ctl_t  s3_ctl;
	logic [PW-1:0]        s3_pos;
	logic signed [LW+1:0] s3_sc_p, s3_sc_s;

	dswc_score #(.WB(WB), .PW(PW)) u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.s1_valid (s1_valid),
		.s1_ctl   (s1_ctl),
		.s1_pos   (s1_pos),
		.mis_p    (mis_p),
		.mis_s    (mis_s),
		.len      (len),
		.sec_en   (sen_q),
		.s3_valid (s3_valid),
		.s3_ctl   (s3_ctl),
		.s3_pos   (s3_pos),
		.s3_sc_p  (s3_sc_p),
		.s3_sc_s  (s3_sc_s)
	);

	// Peak tracking and result
	logic                            r_found, r_type;
	logic [dswc_pkg::LOC_W-1:0]      r_loc;
	logic [dswc_pkg::PEAK_W-1:0]     r_peak;

	dswc_peak #(.WB(WB), .PW(PW)) u_peak (
		.clk       (clk),
		.arst_n    (arst_n),
		.s3_valid  (s3_valid),
		.s3_ctl    (s3_ctl),
		.s3_pos    (s3_pos),
		.s3_sc_p   (s3_sc_p),
		.s3_sc_s   (s3_sc_s),
		.thr       (thr_q),
		.adv       (adv),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_found (r_found),
		.out_loc   (r_loc),
		.out_type  (r_type),
		.out_peak  (r_peak)
	);

	assign m_axis_tdata = {7'd0, r_peak, r_loc, r_found};
	assign m_axis_tuser = r_type;

endmodule

@@ tb/sync_result_checker.sv @@
`timescale 1ns / 1ps
module sync_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [0] rx_bit
	input  logic [0:0]                     s_axis_tuser,   // [0] block_start
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [23:0]                    m_axis_tdata,   // [0] found, [10:1] location,
	                                                       // [16:11] peak_score
	input  logic [0:0]                     m_axis_tuser,   // [0] word_type
	input  logic                           cfg_wr_en,
	input  logic [dswc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dswc_pkg::WORD_W-1:0]    cfg_data,
	output int                             fail_count,
	output int                             pending_count,
	output int                             result_count
);

	localparam int WORD_LIMIT = (dswc_pkg::DEF_MAX_WORD_BITS < 32) ?
		dswc_pkg::DEF_MAX_WORD_BITS : 32;

	typedef struct packed {
		logic                        found;
		logic [dswc_pkg::LOC_W-1:0]  location;
		logic                        word_type;
		logic [dswc_pkg::PEAK_W-1:0] peak;
	} sync_report_t;

	// Register shadow
	logic [dswc_pkg::WORD_W-1:0]    primary_q;
	logic [dswc_pkg::WORD_W-1:0]    secondary_q;
	logic                           sec_en_q;
	logic [dswc_pkg::LEN_W-1:0]     len_q;
	logic [dswc_pkg::THR_W-1:0]     thr_q;
	logic [dswc_pkg::POS_CFG_W-1:0] npos_q;

	// Search state
	logic [31:0] window_q;
	int          bits_q;
	int          best_q;
	int          best_loc_q;
	logic        best_type_q;

	sync_report_t expected_reports[$];
	sync_report_t want;

	function automatic int mismatches(input logic [31:0] diff);
		int n;
		n = 0;
		for (int i = 0; i < 32; i++)
			n += diff[i];
		return n;
	endfunction

	// Advance the search by one received bit; queue a report at block end
	task automatic correlate_bit(input logic rx_bit, input logic start);
		int len;
		int npos;
		int total;
		int s_pri;
		int s_sec;
		logic [31:0] mask;
		sync_report_t rep;
		len = (len_q < 1) ? 1 : ((len_q > WORD_LIMIT) ? WORD_LIMIT : int'(len_q));
		npos = (npos_q < 1) ? 1 :
			((npos_q > dswc_pkg::DEF_MAX_POSITIONS) ? dswc_pkg::DEF_MAX_POSITIONS :
			int'(npos_q));
		total = npos + len - 1;
		mask = 32'((64'd1 << len) - 64'd1);
		if (start) begin
			window_q = '0;
			bits_q = 0;
			best_q = 0;
			best_loc_q = 0;
			best_type_q = 1'b0;
		end
		// past block end: bits are dropped until the next block start
		if (bits_q >= total)
			return;
		window_q = ((window_q >> 1) | (32'(rx_bit) << (len - 1))) & mask;
		bits_q++;
		if (bits_q >= len) begin
			s_pri = len - 2 * mismatches((window_q ^ primary_q) & mask);
			s_sec = sec_en_q ? len - 2 * mismatches((window_q ^ secondary_q) & mask) : 0;
			// secondary first, strict compare keeps earliest peak
			if (s_sec > best_q) begin
				best_q = s_sec;
				best_loc_q = bits_q - len;
				best_type_q = 1'b1;
			end
			if (s_pri > best_q) begin
				best_q = s_pri;
				best_loc_q = bits_q - len;
				best_type_q = 1'b0;
			end
		end
		if (bits_q == total) begin
			rep.found = (best_q >= int'(thr_q));
			rep.location = best_loc_q[dswc_pkg::LOC_W-1:0];
			rep.word_type = best_type_q;
			rep.peak = best_q[dswc_pkg::PEAK_W-1:0];
			expected_reports.push_back(rep);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, exp_val, got_val);
			fail_count++;
		end
	endtask

	// Predict on input transfers, track register writes, check output transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_q = '0;
			secondary_q = '0;
			sec_en_q = 1'b0;
			len_q = dswc_pkg::RST_WORD_LENGTH;
			thr_q = dswc_pkg::RST_THRESHOLD;
			npos_q = dswc_pkg::RST_POSITIONS;
			window_q = '0;
			bits_q = 0;
			best_q = 0;
			best_loc_q = 0;
			best_type_q = 1'b0;
			expected_reports.delete();
			fail_count = 0;
			pending_count = 0;
			result_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				correlate_bit(s_axis_tdata[0], s_axis_tuser[0]);
			if (cfg_wr_en) begin
				case (cfg_index)
					dswc_pkg::REG_PRIMARY_WORD:     primary_q = cfg_data;
					dswc_pkg::REG_SECONDARY_WORD:   secondary_q = cfg_data;
					dswc_pkg::REG_SECONDARY_ENABLE: sec_en_q = cfg_data[0];
					dswc_pkg::REG_WORD_LENGTH:      len_q = cfg_data[dswc_pkg::LEN_W-1:0];
					dswc_pkg::REG_DETECT_THRESHOLD: thr_q = cfg_data[dswc_pkg::THR_W-1:0];
					dswc_pkg::REG_SEARCH_POSITIONS:
						npos_q = cfg_data[dswc_pkg::POS_CFG_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0b %0d %0b %0d",
						$time, m_axis_tdata[0], m_axis_tdata[10:1], m_axis_tuser[0],
						m_axis_tdata[16:11]);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("found", 32'(want.found), 32'(m_axis_tdata[0]));
					check_field("location", 32'(want.location), 32'(m_axis_tdata[10:1]));
					check_field("word_type", 32'(want.word_type), 32'(m_axis_tuser[0]));
					check_field("peak_score", 32'(want.peak), 32'(m_axis_tdata[16:11]));
					result_count++;
				end
			end
			pending_count = expected_reports.size();
		end
	end

endmodule

@@ tb/dual_sync_word_correlator_top_tb.sv @@
`timescale 1ns / 1ps
module dual_sync_word_correlator_top_tb;

	localparam int RANDOM_ITEMS = 380;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 250000;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata;   // [0] rx_bit
	logic [0:0]                     s_axis_tuser;   // [0] block_start
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [23:0]                    m_axis_tdata;   // [0] found, [10:1] location,
	                                                // [16:11] peak_score
	logic [0:0]                     m_axis_tuser;   // [0] word_type
	logic                           cfg_wr_en;
	logic [dswc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dswc_pkg::WORD_W-1:0]    cfg_data;

	int fail_count;
	int pending_count;
	int result_count;

	// Traffic shaping
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_phase = 1'b0;
	bit hold_done = 1'b0;
	int hold_cycles = 0;
	int cycle_count = 0;

	// Stimulus bookkeeping and copy of the programmed words
	int          items_sent = 0;
	int          blocks_sent = 0;
	int          settings_used = 0;
	logic [31:0] cfg_prim = '0;
	logic [31:0] cfg_sec = '0;
	logic        cfg_sec_en = 1'b0;

	dual_sync_word_correlator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	sync_result_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.result_count  (result_count)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Result side: one long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_phase && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_cycles++;
			if (hold_cycles >= HOLD_CYCLES)
				hold_done = 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("dual_sync_word_correlator_top_tb NOT OK");
			$finish;
		end
	end

	function automatic int clamp_range(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic set_traffic(input int mode);
		case (mode)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 69; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 69; end
			default: begin idle_pct = 35; stall_pct = 35; end
		endcase
	endtask

	// One bit transfer, with random idle cycles in front
	task automatic push_bit(input logic rx, input logic start);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, rx};
		s_axis_tuser <= start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Stop sending and let every outstanding report come out of the pipeline
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input dswc_pkg::dswc_reg_t idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [31:0] prim, input logic [31:0] sec,
		input logic en, input int len, input int thr, input int npos);
		write_reg(dswc_pkg::REG_PRIMARY_WORD, prim);
		write_reg(dswc_pkg::REG_SECONDARY_WORD, sec);
		write_reg(dswc_pkg::REG_SECONDARY_ENABLE, 32'(en));
		write_reg(dswc_pkg::REG_WORD_LENGTH, 32'(len));
		write_reg(dswc_pkg::REG_DETECT_THRESHOLD, 32'(thr));
		write_reg(dswc_pkg::REG_SEARCH_POSITIONS, 32'(npos));
		cfg_wr_en <= 1'b0;
		cfg_prim = prim;
		cfg_sec = sec;
		cfg_sec_en = en;
		settings_used++;
	endtask

	// One search block of random bits, usually with a word planted in it.
	// Loose blocks may flip word bits, end early or trail ignored bits.
	task automatic run_block(input int len, input int npos, input int embed_at,
		input bit open_start, input bit exact);
		int total;
		int cut;
		int extra;
		int spot;
		logic [31:0] word;
		logic rx;
		total = npos + len - 1;
		spot = embed_at;
		if (spot < 0 && $urandom_range(9) < 7)
			spot = $urandom_range(npos - 1);
		word = (!exact && cfg_sec_en && $urandom_range(1)) ? cfg_sec : cfg_prim;
		cut = total;
		extra = 0;
		if (!exact) begin
			repeat ($urandom_range(2)) word[$urandom_range(len - 1)] ^= 1'b1;
			if ($urandom_range(9) == 0)
				cut = $urandom_range(1, total);
			if ($urandom_range(9) == 0)
				extra = $urandom_range(1, 4);
		end
		for (int k = 0; k < cut + extra; k++) begin
			rx = (spot >= 0 && k >= spot && k < spot + len) ? word[k - spot] : 1'($urandom);
			push_bit(rx, (k == 0) && !open_start);
		end
		items_sent += cut + extra;
		blocks_sent++;
	endtask

	initial begin
		int random_start;
		int phase;
		int len_reg;
		int thr_reg;
		int npos_reg;
		int len_eff;
		int npos_eff;
		logic [31:0] prim;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= dswc_pkg::REG_PRIMARY_WORD;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset words, length and threshold with a short search, no block start
		write_reg(dswc_pkg::REG_SEARCH_POSITIONS, 32'd3);
		cfg_wr_en <= 1'b0;
		run_block(32, 3, 1, 1'b1, 1'b1);
		drain();

		// One-bit words and one position, threshold zero: a report per bit.
		// The result side holds off so the block fills and stalls its input.
		program_regs(32'h0, 32'h1, 1'b1, 0, 0, 0);
		hold_phase = 1'b1;
		for (int k = 0; k < 40; k++)
			push_bit(1'($urandom), 1'b1);
		items_sent += 40;
		blocks_sent += 40;
		drain();

		// Exact full-length primary match at position zero, top threshold
		program_regs(32'hC3A5_96F0, ~32'hC3A5_96F0, 1'b1, 32, 32, 2);
		run_block(32, 2, 0, 1'b0, 1'b1);
		drain();

		// Both words equal: secondary wins the tie at the same position
		program_regs(32'h0000_005A, 32'h0000_005A, 1'b1, 8, 8, 3);
		run_block(8, 3, 1, 1'b0, 1'b1);
		drain();

		// Random settings, cycling through the traffic modes
		random_start = items_sent;
		phase = 0;
		while (items_sent - random_start < RANDOM_ITEMS || phase < 4) begin
			set_traffic(phase % 4);
			case ($urandom_range(9))
				0: len_reg = 1;
				1: len_reg = 32;
				2: len_reg = $urandom_range(33, 63);
				default: len_reg = $urandom_range(2, 31);
			endcase
			len_eff = clamp_range(len_reg, 1, 32);
			npos_reg = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 24);
			npos_eff = clamp_range(npos_reg, 1, 1024);
			case ($urandom_range(9))
				0: thr_reg = 1;
				1: thr_reg = 32;
				2: thr_reg = $urandom_range(1) ? 0 : $urandom_range(33, 63);
				default: thr_reg = $urandom_range(1, len_eff);
			endcase
			prim = $urandom;
			program_regs(prim, ($urandom_range(9) == 0) ? prim : 32'($urandom),
				1'($urandom), len_reg, thr_reg, npos_reg);
			repeat ($urandom_range(2, 3))
				run_block(len_eff, npos_eff, -1, 1'b0, 1'b0);
			drain();
			phase++;
		end

		// Oversized length and position count saturate; peak at the last window
		set_traffic(3);
		program_regs($urandom, $urandom, 1'b1, 45, 63, 2000);
		run_block(32, 1024, 1023, 1'b0, 1'b1);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d bits in %0d blocks under %0d register settings; %0d reports checked.",
			items_sent, blocks_sent, settings_used, result_count);
		$display("Traffic ran free, with sender gaps, receiver stalls, both, and a %0d-cycle hold.",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("dual_sync_word_correlator_top_tb OK");
		else
			$display("dual_sync_word_correlator_top_tb NOT OK");
		$finish;
	end

endmodule
